// ===== hdl/cbo_pkg.sv =====
// ----------------------------------------------------------------------------
// cbo_pkg
// shared widths and the per-request side data carried down the pipeline
// ----------------------------------------------------------------------------
package cbo_pkg;

  localparam int CW            = 24;                 // centre coordinate width
  localparam int SW            = 16;                 // size width
  localparam int DIR_FRAC_BITS = 16;                 // fraction bits of the direction
  localparam int SQW           = 2 * CW + 1;         // sum of two squares
  localparam int RW            = (SQW + 1) / 2;      // integer root width
  localparam int QW            = DIR_FRAC_BITS + 1;  // direction magnitude, at most 1.0
  localparam int NW            = CW + DIR_FRAC_BITS; // dividend width
  localparam int OW            = QW + SW - DIR_FRAC_BITS; // scaled step width

  typedef struct packed {
    logic          cb;         // circle against box
    logic          fixed_hit;  // result for the other two cases
    logic [SW-1:0] r;          // circle radius
    logic [SW-1:0] h;          // box half-width
    logic [CW-1:0] mx;
    logic [CW-1:0] my;
  } carry_t;

endpackage

// ===== hdl/cbo_prep.sv =====
// ----------------------------------------------------------------------------
// cbo_prep
// centre distances, squares, and the circle/circle and box/box results
// ----------------------------------------------------------------------------
module cbo_prep (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   v_in,
  input  logic [cbo_pkg::CW-1:0] first_x,
  input  logic [cbo_pkg::CW-1:0] first_y,
  input  logic [cbo_pkg::SW-1:0] first_size,
  input  logic                   first_is_box,
  input  logic [cbo_pkg::CW-1:0] second_x,
  input  logic [cbo_pkg::CW-1:0] second_y,
  input  logic [cbo_pkg::SW-1:0] second_size,
  input  logic                   second_is_box,
  output logic                   v_out,
  output logic [cbo_pkg::SQW-1:0] n_out,
  output cbo_pkg::carry_t        c_out
);
  import cbo_pkg::*;

  logic [CW:0]      dx, dy;
  logic [CW-1:0]    mx_nxt, my_nxt;
  logic [SW:0]      sum_nxt;

  logic             v1_r, v2_r, v3_r;
  logic [CW-1:0]    mx1_r, my1_r;
  logic [SW:0]      sum1_r;
  logic             cb1_r, bb1_r;
  logic [SW-1:0]    r1_r, h1_r;

  logic [2*CW-1:0]  sqx2_r, sqy2_r;
  logic [2*SW+1:0]  sumsq2_r;
  logic             bbhit2_r;
  logic             cb2_r, bb2_r;
  logic [SW-1:0]    r2_r, h2_r;
  logic [CW-1:0]    mx2_r, my2_r;

  logic [SQW-1:0]   n_nxt;
  logic [SQW-1:0]   n3_r;
  carry_t           c3_r;

  assign dx      = {second_x[CW-1], second_x} - {first_x[CW-1], first_x};
  assign dy      = {second_y[CW-1], second_y} - {first_y[CW-1], first_y};
  assign mx_nxt  = dx[CW] ? CW'(-dx) : dx[CW-1:0];
  assign my_nxt  = dy[CW] ? CW'(-dy) : dy[CW-1:0];
  assign sum_nxt = {1'b0, first_size} + {1'b0, second_size};
  assign n_nxt   = {1'b0, sqx2_r} + {1'b0, sqy2_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else if (adv) begin
      v1_r <= v_in;
      v2_r <= v1_r;
      v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      mx1_r  <= mx_nxt;
      my1_r  <= my_nxt;
      sum1_r <= sum_nxt;
      cb1_r  <= first_is_box ^ second_is_box;
      bb1_r  <= first_is_box & second_is_box;
      r1_r   <= first_is_box ? second_size : first_size;
      h1_r   <= first_is_box ? first_size : second_size;

      sqx2_r   <= (2*CW)'(mx1_r) * (2*CW)'(mx1_r);
      sqy2_r   <= (2*CW)'(my1_r) * (2*CW)'(my1_r);
      sumsq2_r <= (2*SW+2)'(sum1_r) * (2*SW+2)'(sum1_r);
      bbhit2_r <= (mx1_r <= CW'(sum1_r)) && (my1_r <= CW'(sum1_r));
      cb2_r    <= cb1_r;
      bb2_r    <= bb1_r;
      r2_r     <= r1_r;
      h2_r     <= h1_r;
      mx2_r    <= mx1_r;
      my2_r    <= my1_r;

      n3_r           <= n_nxt;
      c3_r.cb        <= cb2_r;
      c3_r.fixed_hit <= bb2_r ? bbhit2_r : (n_nxt <= SQW'(sumsq2_r));
      c3_r.r         <= r2_r;
      c3_r.h         <= h2_r;
      c3_r.mx        <= mx2_r;
      c3_r.my        <= my2_r;
    end
  end

  assign v_out = v3_r;
  assign n_out = n3_r;
  assign c_out = c3_r;

endmodule

// ===== hdl/cbo_sqrt.sv =====
// ----------------------------------------------------------------------------
// cbo_sqrt
// pipelined integer square root, one root bit per stage
// ----------------------------------------------------------------------------
module cbo_sqrt (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    adv,
  input  logic                    v_in,
  input  logic [cbo_pkg::SQW-1:0] n_in,
  input  cbo_pkg::carry_t         c_in,
  output logic                    v_out,
  output logic [cbo_pkg::RW-1:0]  root_out,
  output cbo_pkg::carry_t         c_out
);
  import cbo_pkg::*;

  localparam int TW = SQW + 2;

  logic           st_v    [RW+1];
  logic [SQW-1:0] st_rem  [RW+1];
  logic [RW-1:0]  st_root [RW+1];
  carry_t         st_c    [RW+1];

  logic           v_r    [RW];
  logic [SQW-1:0] rem_r  [RW];
  logic [RW-1:0]  root_r [RW];
  carry_t         c_r    [RW];

  assign st_v[0]    = v_in;
  assign st_rem[0]  = n_in;
  assign st_root[0] = '0;
  assign st_c[0]    = c_in;

  for (genvar k = 0; k < RW; k++) begin : g_stage
    localparam int B = RW - 1 - k;
    logic [TW-1:0] trial;
    logic          ge;

    // (root + 2^b)^2 - root^2, root holding only bits above b
    assign trial = (TW'(st_root[k]) << (B + 1)) | (TW'(1) << (2 * B));
    assign ge    = TW'(st_rem[k]) >= trial;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[k]  <= ge ? SQW'(TW'(st_rem[k]) - trial) : st_rem[k];
        root_r[k] <= st_root[k] | (RW'(ge) << B);
        c_r[k]    <= st_c[k];
      end
    end

    assign st_v[k+1]    = v_r[k];
    assign st_rem[k+1]  = rem_r[k];
    assign st_root[k+1] = root_r[k];
    assign st_c[k+1]    = c_r[k];
  end

  assign v_out    = st_v[RW];
  assign root_out = st_root[RW];
  assign c_out    = st_c[RW];

endmodule

// ===== hdl/cbo_div.sv =====
// ----------------------------------------------------------------------------
// cbo_div
// two-lane restoring divider: direction magnitudes |dx|/len and |dy|/len
// ----------------------------------------------------------------------------
module cbo_div (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   v_in,
  input  logic [cbo_pkg::RW-1:0] len_in,
  input  cbo_pkg::carry_t        c_in,
  output logic                   v_out,
  output logic [cbo_pkg::QW-1:0] qx_out,
  output logic [cbo_pkg::QW-1:0] qy_out,
  output cbo_pkg::carry_t        c_out
);
  import cbo_pkg::*;

  localparam int DW = RW + QW;

  logic          st_v   [QW+1];
  logic [NW-1:0] st_rx  [QW+1];
  logic [NW-1:0] st_ry  [QW+1];
  logic [QW-1:0] st_qx  [QW+1];
  logic [QW-1:0] st_qy  [QW+1];
  logic [RW-1:0] st_len [QW+1];
  carry_t        st_c   [QW+1];

  logic          v_r   [QW];
  logic [NW-1:0] rx_r  [QW];
  logic [NW-1:0] ry_r  [QW];
  logic [QW-1:0] qx_r  [QW];
  logic [QW-1:0] qy_r  [QW];
  logic [RW-1:0] len_r [QW];
  carry_t        c_r   [QW];

  assign st_v[0]   = v_in;
  assign st_rx[0]  = NW'(c_in.mx) << DIR_FRAC_BITS;
  assign st_ry[0]  = NW'(c_in.my) << DIR_FRAC_BITS;
  assign st_qx[0]  = '0;
  assign st_qy[0]  = '0;
  assign st_len[0] = len_in;
  assign st_c[0]   = c_in;

  for (genvar k = 0; k < QW; k++) begin : g_stage
    localparam int B = QW - 1 - k;
    logic [DW-1:0] dsh;
    logic          gex, gey;

    assign dsh = DW'(st_len[k]) << B;
    assign gex = DW'(st_rx[k]) >= dsh;
    assign gey = DW'(st_ry[k]) >= dsh;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (adv) begin
        v_r[k] <= st_v[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rx_r[k]  <= gex ? NW'(DW'(st_rx[k]) - dsh) : st_rx[k];
        ry_r[k]  <= gey ? NW'(DW'(st_ry[k]) - dsh) : st_ry[k];
        qx_r[k]  <= st_qx[k] | (QW'(gex) << B);
        qy_r[k]  <= st_qy[k] | (QW'(gey) << B);
        len_r[k] <= st_len[k];
        c_r[k]   <= st_c[k];
      end
    end

    assign st_v[k+1]   = v_r[k];
    assign st_rx[k+1]  = rx_r[k];
    assign st_ry[k+1]  = ry_r[k];
    assign st_qx[k+1]  = qx_r[k];
    assign st_qy[k+1]  = qy_r[k];
    assign st_len[k+1] = len_r[k];
    assign st_c[k+1]   = c_r[k];
  end

  assign v_out  = st_v[QW];
  assign qx_out = st_qx[QW];
  assign qy_out = st_qy[QW];
  assign c_out  = st_c[QW];

endmodule

// ===== hdl/cbo_final.sv =====
// ----------------------------------------------------------------------------
// cbo_final
// scales the direction by the radius and tests the stepped point in the box
// ----------------------------------------------------------------------------
module cbo_final (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   adv,
  input  logic                   v_in,
  input  logic [cbo_pkg::QW-1:0] qx_in,
  input  logic [cbo_pkg::QW-1:0] qy_in,
  input  cbo_pkg::carry_t        c_in,
  output logic                   v_out,
  output logic                   hit_out
);
  import cbo_pkg::*;

  localparam int PW = QW + SW;

  logic [PW-1:0] px, py;
  logic          v_r;
  logic [OW-1:0] ox_r, oy_r;
  carry_t        c_r;
  logic [CW:0]   ex, ey;
  logic [CW-1:0] ax, ay;
  logic          cb_hit;

  assign px = PW'(qx_in) * PW'(c_in.r);
  assign py = PW'(qy_in) * PW'(c_in.r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= 1'b0;
    end else if (adv) begin
      v_r <= v_in;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ox_r <= px[PW-1:DIR_FRAC_BITS];
      oy_r <= py[PW-1:DIR_FRAC_BITS];
      c_r  <= c_in;
    end
  end

  assign ex = (CW+1)'(ox_r) - (CW+1)'(c_r.mx);
  assign ey = (CW+1)'(oy_r) - (CW+1)'(c_r.my);
  assign ax = ex[CW] ? CW'(-ex) : ex[CW-1:0];
  assign ay = ey[CW] ? CW'(-ey) : ey[CW-1:0];

  // coincident centres have no direction, so no hit
  assign cb_hit = (ax <= CW'(c_r.h)) && (ay <= CW'(c_r.h))
                  && ((c_r.mx != '0) || (c_r.my != '0));

  assign v_out   = v_r;
  assign hit_out = c_r.cb ? cb_hit : c_r.fixed_hit;

endmodule

// ===== hdl/circle_box_overlap_test.sv =====
// ----------------------------------------------------------------------------
// circle_box_overlap_test
// overlap test of two shapes, each a circle or a square axis-aligned box
// ----------------------------------------------------------------------------
// Each input request carries two shapes (centre, size, box flag) on in_*;
// each produces exactly one out_hit request, in order.
// Both channels use valid/stall: a request moves on an edge with valid high
// and stall low.
// The pipeline has 3 + 25 + (DIR_FRAC_BITS + 1) + 2 register stages, 47
// at the default of 16 fraction bits: three for distances and squares, one
// per root bit in the square root, one per quotient bit in the divider, one
// for the radius multiply and the output register.
// One request per cycle when not stalled; every stage is a register step.
// When out_stall is high with a result waiting, the whole pipeline holds
// and in_stall follows it in the same cycle; nothing is dropped.
// Synchronous reset clears all valid bits; no result is shown after reset
// until a request has run through.
// ----------------------------------------------------------------------------
module circle_box_overlap_test (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [cbo_pkg::CW-1:0] in_first_x,
  input  logic [cbo_pkg::CW-1:0] in_first_y,
  input  logic [cbo_pkg::SW-1:0] in_first_size,
  input  logic                   in_first_is_box,
  input  logic [cbo_pkg::CW-1:0] in_second_x,
  input  logic [cbo_pkg::CW-1:0] in_second_y,
  input  logic [cbo_pkg::SW-1:0] in_second_size,
  input  logic                   in_second_is_box,
  output logic                   out_valid,
  input  logic                   out_stall,
  output logic                   out_hit
);
  import cbo_pkg::*;

  logic           adv;
  logic           p_v, s_v, d_v, f_v, f_hit;
  logic [SQW-1:0] p_n;
  logic [RW-1:0]  s_root;
  logic [QW-1:0]  d_qx, d_qy;
  carry_t         p_c, s_c, d_c;
  logic           out_valid_r, out_hit_r;

  assign adv      = !out_valid_r || !out_stall;
  assign in_stall = !adv;

  cbo_prep u_prep (
    .clk, .rst_n, .adv,
    .v_in          (in_valid),
    .first_x       (in_first_x),
    .first_y       (in_first_y),
    .first_size    (in_first_size),
    .first_is_box  (in_first_is_box),
    .second_x      (in_second_x),
    .second_y      (in_second_y),
    .second_size   (in_second_size),
    .second_is_box (in_second_is_box),
    .v_out         (p_v),
    .n_out         (p_n),
    .c_out         (p_c)
  );

  cbo_sqrt u_sqrt (
    .clk, .rst_n, .adv,
    .v_in     (p_v),
    .n_in     (p_n),
    .c_in     (p_c),
    .v_out    (s_v),
    .root_out (s_root),
    .c_out    (s_c)
  );

  cbo_div u_div (
    .clk, .rst_n, .adv,
    .v_in   (s_v),
    .len_in (s_root),
    .c_in   (s_c),
    .v_out  (d_v),
    .qx_out (d_qx),
    .qy_out (d_qy),
    .c_out  (d_c)
  );

  cbo_final u_final (
    .clk, .rst_n, .adv,
    .v_in    (d_v),
    .qx_in   (d_qx),
    .qy_in   (d_qy),
    .c_in    (d_c),
    .v_out   (f_v),
    .hit_out (f_hit)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= f_v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_hit_r <= f_hit;
    end
  end

  assign out_valid = out_valid_r;
  assign out_hit   = out_hit_r;

  // pipeline only holds back input when a finished result is blocked
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (out_valid && out_stall))
    else $error("input stalled without a blocked result");

  a_reset_clears: assert property (@(posedge clk)
    $rose(rst_n) |-> !out_valid)
    else $error("result valid straight after reset");

  a_hold_stage: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |=> ($stable(p_v) && $stable(s_v) && $stable(d_v)))
    else $error("pipeline moved during a stall");

endmodule

// ===== tb/sv/tb_circle_box_overlap_test.sv =====
// ----------------------------------------------------------------------------
// tb_circle_box_overlap_test
// checks the shape overlap test against a bit-exact predictor
// ----------------------------------------------------------------------------
// A queue of shape pairs feeds a driver that sends them in bursts with gaps.
// A monitor works out the expected hit bit for each accepted request and
// compares it with out_hit, in order. The receiver stalls in phases: none,
// light and heavy. Directed pairs cover extreme coordinates, coincident
// centres, exact touching and every shape combination. Random pairs are
// mostly placed near each other so that hits and misses both occur.
// ----------------------------------------------------------------------------
module tb_circle_box_overlap_test;
  timeunit 1ns;
  timeprecision 1ps;

  import cbo_pkg::*;

  localparam int WATCHDOG_LIMIT = 5000;
  localparam int RANDOM_PAIRS   = 550;

  typedef struct {
    logic [CW-1:0] ax, ay;
    logic [SW-1:0] as;
    logic          ab;
    logic [CW-1:0] bx, by;
    logic [SW-1:0] bs;
    logic          bb;
    bit            drain_first;  // hold off until every result is back
  } shape_pair_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_valid = 1'b0;
  logic          in_stall;
  logic [CW-1:0] in_first_x = '0;
  logic [CW-1:0] in_first_y = '0;
  logic [SW-1:0] in_first_size = '0;
  logic          in_first_is_box = 1'b0;
  logic [CW-1:0] in_second_x = '0;
  logic [CW-1:0] in_second_y = '0;
  logic [SW-1:0] in_second_size = '0;
  logic          in_second_is_box = 1'b0;
  logic          out_valid;
  logic          out_stall = 1'b0;
  logic          out_hit;

  shape_pair_t pending_pairs[$];
  bit          expected_hits[$];
  int          errors = 0;
  int          sent_count = 0;
  int          accepted_count = 0;
  int          idle_cycles = 0;
  int          burst_left = 0;
  int          gap_left = 0;
  int          stall_phase_left = 0;
  int          stall_mode = 0;

  circle_box_overlap_test dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, b;
    res = 0;
    b = 64'd1 << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= res + b) begin
        n -= res + b;
        res = (res >> 1) + b;
      end else begin
        res >>= 1;
      end
      b >>= 2;
    end
    return res;
  endfunction

  function automatic longint unsigned abs_diff(logic [CW-1:0] p, logic [CW-1:0] q);
    longint d;
    d = longint'($signed(q)) - longint'($signed(p));
    return d < 0 ? longint'(-d) : d;
  endfunction

  // mx, my: centre distance; r: circle radius; h: box half-width
  function automatic bit circle_meets_box(longint unsigned mx, longint unsigned my,
                                          longint unsigned r, longint unsigned h);
    longint unsigned len, qx, qy, ox, oy, ex, ey;
    if (mx == 0 && my == 0) return 1'b0;
    len = int_sqrt(mx * mx + my * my);
    if (len == 0) return 1'b0;
    qx = (mx << DIR_FRAC_BITS) / len;
    qy = (my << DIR_FRAC_BITS) / len;
    ox = (qx * r) >> DIR_FRAC_BITS;
    oy = (qy * r) >> DIR_FRAC_BITS;
    ex = ox > mx ? ox - mx : mx - ox;
    ey = oy > my ? oy - my : my - oy;
    return ex <= h && ey <= h;
  endfunction

  function automatic bit shapes_overlap(shape_pair_t p);
    longint unsigned mx, my, sum;
    mx = abs_diff(p.ax, p.bx);
    my = abs_diff(p.ay, p.by);
    sum = longint'(p.as) + longint'(p.bs);
    if (p.ab && p.bb) return mx <= sum && my <= sum;
    if (p.ab) return circle_meets_box(mx, my, p.bs, p.as);
    if (p.bb) return circle_meets_box(mx, my, p.as, p.bs);
    return mx * mx + my * my <= sum * sum;
  endfunction

  task automatic report_mismatch(string what);
    errors++;
    $display("mismatch at %0t: %s", $time, what);
  endtask

  task automatic add_pair(int ax, int ay, int as, bit ab,
                          int bx, int by, int bs, bit bb, bit drain = 1'b0);
    shape_pair_t p;
    p.ax = CW'(ax); p.ay = CW'(ay); p.as = SW'(as); p.ab = ab;
    p.bx = CW'(bx); p.by = CW'(by); p.bs = SW'(bs); p.bb = bb;
    p.drain_first = drain;
    pending_pairs.push_back(p);
  endtask

  function automatic int random_size();
    case ($urandom_range(0, 3))
      0: return $urandom_range(0, 65535);
      1: return $urandom_range(0, 255);
      2: return 65535;
      default: return $urandom_range(0, 8191);
    endcase
  endfunction

  // driver: one request presented at a time, held while stalled
  always @(negedge clk) begin
    if (rst_n) begin
      if (!in_valid || accepted_count == sent_count) begin
        if (pending_pairs.size() != 0 && gap_left == 0 &&
            !(pending_pairs[0].drain_first &&
              (expected_hits.size() != 0 || accepted_count != sent_count))) begin
          in_first_x       <= pending_pairs[0].ax;
          in_first_y       <= pending_pairs[0].ay;
          in_first_size    <= pending_pairs[0].as;
          in_first_is_box  <= pending_pairs[0].ab;
          in_second_x      <= pending_pairs[0].bx;
          in_second_y      <= pending_pairs[0].by;
          in_second_size   <= pending_pairs[0].bs;
          in_second_is_box <= pending_pairs[0].bb;
          void'(pending_pairs.pop_front());
          in_valid <= 1'b1;
          sent_count++;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 40);
            gap_left = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
          if (gap_left > 0) gap_left--;
        end
      end
      // receiver stall pattern
      if (stall_phase_left == 0) begin
        stall_phase_left = $urandom_range(20, 120);
        stall_mode = $urandom_range(0, 2);
      end else begin
        stall_phase_left--;
      end
      case (stall_mode)
        0: out_stall <= 1'b0;
        1: out_stall <= $urandom_range(0, 3) == 0;
        default: out_stall <= $urandom_range(0, 4) != 0;
      endcase
    end
  end

  // monitor
  always @(posedge clk) begin
    shape_pair_t p;
    bit want;
    bit moved;
    if (rst_n) begin
      moved = 1'b0;
      if (in_valid && !in_stall) begin
        p.ax = in_first_x;  p.ay = in_first_y;  p.as = in_first_size;
        p.ab = in_first_is_box;
        p.bx = in_second_x; p.by = in_second_y; p.bs = in_second_size;
        p.bb = in_second_is_box;
        expected_hits.push_back(shapes_overlap(p));
        accepted_count++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (expected_hits.size() == 0) begin
          report_mismatch("result with no request outstanding");
        end else begin
          want = expected_hits.pop_front();
          if (out_hit !== want)
            report_mismatch($sformatf("hit %b, expected %b", out_hit, want));
        end
      end
      idle_cycles <= moved ? 0 : idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("timeout after %0d idle cycles", idle_cycles);
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  initial begin
    int sx, sy, reach;
    bit ab, bb;
    // directed pairs
    add_pair(-8388608, -8388608, 65535, 1, 8388607, 8388607, 65535, 1);
    add_pair(-8388608, 8388607, 65535, 0, 8388607, -8388608, 65535, 0);
    add_pair(-8388608, -8388608, 65535, 0, 8388607, 8388607, 65535, 1);
    add_pair(8388607, 8388607, 65535, 1, -8388608, -8388608, 0, 0);
    add_pair(1000, -2000, 300, 0, 1000, -2000, 300, 0);     // coincident circles
    add_pair(1000, -2000, 300, 1, 1000, -2000, 300, 1);     // coincident boxes
    add_pair(1000, -2000, 300, 0, 1000, -2000, 300, 1);     // coincident mixed
    add_pair(1000, -2000, 300, 1, 1000, -2000, 300, 0);
    add_pair(0, 0, 0, 0, 0, 0, 0, 0);
    add_pair(0, 0, 256, 0, 768, 1024, 1024, 0);             // circles touching
    add_pair(0, 0, 256, 0, 768, 1025, 1024, 0);             // just apart
    add_pair(0, 0, 500, 1, 1000, -1000, 500, 1);            // box corners touching
    add_pair(0, 0, 500, 1, 1001, 0, 500, 1);
    add_pair(0, 0, 600, 0, 1000, 0, 400, 1);                // circle meets box edge
    add_pair(0, 0, 599, 0, 0, -1000, 400, 1);
    add_pair(5000, 5000, 700, 1, 4000, 4000, 800, 0);
    add_pair(-1, -1, 1, 0, 0, 0, 0, 1);
    add_pair(1, 0, 65535, 0, 0, 0, 0, 1);
    add_pair(8388607, 0, 0, 1, -8388608, 0, 65535, 0);
    add_pair(-12345, 6789, 4321, 0, 23456, -7654, 30000, 1, 1'b1);
    // random pairs, mostly close together
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      sx = $urandom_range(0, 16777215) - 8388608;
      sy = $urandom_range(0, 16777215) - 8388608;
      ab = 1'($urandom_range(0, 1));
      bb = 1'($urandom_range(0, 1));
      if ($urandom_range(0, 7) == 0) begin
        add_pair(sx, sy, random_size(), ab,
                 $urandom_range(0, 16777215), $urandom_range(0, 16777215),
                 random_size(), bb, i == 300);
      end else begin
        int as, bs;
        as = random_size();
        bs = random_size();
        reach = as + bs + $urandom_range(0, 64);
        add_pair(sx, sy, as, ab,
                 sx + $urandom_range(0, 2 * reach) - reach,
                 sy + $urandom_range(0, 2 * reach) - reach, bs, bb, i == 300);
      end
    end
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    wait (pending_pairs.size() == 0 && accepted_count == sent_count &&
          !in_valid && expected_hits.size() == 0);
    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/cbo_pkg.sv
hdl/cbo_prep.sv
hdl/cbo_sqrt.sv
hdl/cbo_div.sv
hdl/cbo_final.sv
hdl/circle_box_overlap_test.sv
tb/sv/tb_circle_box_overlap_test.sv
